>>> design/kpi_pkg.sv
// Shared constants, codes and types for the keyframe position interpolator.
`timescale 1ns / 1ps
package kpi_pkg;

   // Table geometry
   localparam int MAX_KEYS = 64;
   localparam int KEY_AW   = $clog2(MAX_KEYS);
   localparam int CNT_W    = $clog2(MAX_KEYS + 1);

   // Blend weight fraction bits and product width (33-bit delta by 26-bit weight)
   localparam int DT_FRAC  = 24;
   localparam int DCNT_W   = $clog2(DT_FRAC);
   localparam int PROD_W   = 33 + DT_FRAC + 2;

   // Command queue between front and back
   localparam int QDEPTH   = 2;
   localparam int QAW      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCW      = $clog2(QDEPTH + 1);

   // Opcodes
   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_CLEAR  = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;

   // Status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef enum logic [1:0] {
      CMD_APPEND,
      CMD_CLEAR,
      CMD_QUERY,
      CMD_NOP
   } kpi_cmd_type;

   typedef struct packed {
      kpi_cmd_type        cmd;
      logic signed [31:0] key_time;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } kpi_item_type;

   typedef struct packed {
      logic         valid;
      kpi_item_type item;
   } kpi_queue_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_TL,
      S_TN,
      S_SRCH,
      S_SCHK,
      S_BDAT,
      S_EDAT,
      S_DIV,
      S_PRB,
      S_PRE,
      S_PED,
      S_DELTA,
      S_MUL,
      S_ADD,
      S_SELD,
      S_RESP
   } kpi_state_type;

endpackage

>>> design/keyframe_position_interpolator.sv
// Top level of the keyframe position interpolator: front queue and back end.
//
//   channel   ports                                  handshake
//   request   req_opcode, req_in_time, req_in_x/y/z  taken when req_start && !busy
//   response  rsp_out_x/y/z, rsp_status              one-cycle strobe rsp_valid
//
// A taken word is registered in the queue before the back end picks it up.
// Append, clear, no-op and empty-table query words then go straight to the
// response in the back end. A blending query runs clamp checks, lower-bound
// probes into the time RAM (at most ceil(log2(keys+1)) of them) and span
// set-up, then the one-bit-a-cycle weight divider when it runs, then blending
// through one shared multiplier; a zero or negative span ends after the
// probes, and clamped queries skip the search.
// A two-word queue lets requests be taken while the back end works; busy rises
// when it is full. Reset empties the queue and the table. The receiver cannot
// stall.
`timescale 1ns / 1ps
module keyframe_position_interpolator (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_start,
   input  logic [1:0]         req_opcode,
   input  logic signed [31:0] req_in_time,
   input  logic signed [31:0] req_in_x,
   input  logic signed [31:0] req_in_y,
   input  logic signed [31:0] req_in_z,
   output logic               busy,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic [1:0]         rsp_status
);
   import kpi_pkg::*;

   kpi_queue_type head;
   logic          pop;

   kpi_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_start   (req_start),
      .req_opcode  (req_opcode),
      .req_in_time (req_in_time),
      .req_in_x    (req_in_x),
      .req_in_y    (req_in_y),
      .req_in_z    (req_in_z),
      .busy        (busy),
      .head        (head),
      .pop         (pop)
   );

   kpi_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_out_x  (rsp_out_x),
      .rsp_out_y  (rsp_out_y),
      .rsp_out_z  (rsp_out_z),
      .rsp_status (rsp_status)
   );

endmodule

>>> design/kpi_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module kpi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/kpi_front.sv
// Front end: takes command words, classifies the opcode and queues them.
`timescale 1ns / 1ps
module kpi_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_start,
   input  logic [1:0]            req_opcode,
   input  logic signed [31:0]    req_in_time,
   input  logic signed [31:0]    req_in_x,
   input  logic signed [31:0]    req_in_y,
   input  logic signed [31:0]    req_in_z,
   output logic                  busy,
   output kpi_pkg::kpi_queue_type head,
   input  logic                  pop
);
   import kpi_pkg::*;

   kpi_item_type     q_ff [QDEPTH];
   logic [QAW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]   cnt_ff, cnt_in;
   logic             push;
   logic             do_pop;
   kpi_item_type     new_item;
   kpi_cmd_type      cmd;

   assign busy   = (cnt_ff == QCW'(QDEPTH));
   assign push   = req_start && !busy;
   assign do_pop = pop && (cnt_ff != '0);

   // Classify the opcode
   always_comb begin
      case (req_opcode)
         OP_APPEND: cmd = CMD_APPEND;
         OP_CLEAR:  cmd = CMD_CLEAR;
         OP_QUERY:  cmd = CMD_QUERY;
         default:   cmd = CMD_NOP;
      endcase
      new_item.cmd      = cmd;
      new_item.key_time = req_in_time;
      new_item.x        = req_in_x;
      new_item.y        = req_in_y;
      new_item.z        = req_in_z;
   end

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_ff + QAW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_ff + QAW'(1);
      end
      case ({push, do_pop})
         2'b10:   cnt_in = cnt_ff + QCW'(1);
         2'b01:   cnt_in = cnt_ff - QCW'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Hold queued words
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_item;
      end
   end

   assign head.valid = (cnt_ff != '0);
   assign head.item  = q_ff[rd_ptr_ff];

endmodule

>>> design/kpi_back.sv
// Back end: keyframe table, lower-bound search, weight division and blends.
`timescale 1ns / 1ps
module kpi_back (
   input  logic                  clock,
   input  logic                  reset,
   input  kpi_pkg::kpi_queue_type head,
   output logic                  pop,
   output logic                  rsp_valid,
   output logic signed [31:0]    rsp_out_x,
   output logic signed [31:0]    rsp_out_y,
   output logic signed [31:0]    rsp_out_z,
   output logic [1:0]            rsp_status
);
   import kpi_pkg::*;

   kpi_state_type       state_ff, state_in;
   kpi_item_type        item_ff, item_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    lo_ff, lo_in;
   logic [CNT_W-1:0]    len_ff, len_in;
   logic [KEY_AW-1:0]   b_ff, b_in;
   logic [KEY_AW-1:0]   e_ff, e_in;
   logic [31:0]         tb_ff, tb_in;
   logic [31:0]         den_ff, den_in;
   logic [31:0]         rem_ff, rem_in;
   logic [DT_FRAC-1:0]  q_ff, q_in;
   logic [DCNT_W-1:0]   dcnt_ff, dcnt_in;
   logic [DT_FRAC:0]    dt_ff, dt_in;
   logic [95:0]         pb_ff, pb_in;
   logic [95:0]         pe_ff, pe_in;
   logic signed [32:0]  delta_ff, delta_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [1:0]          idx_ff, idx_in;
   logic [31:0]         rx_ff, rx_in, ry_ff, ry_in, rz_ff, rz_in;
   logic [1:0]          st_ff, st_in;

   // Table memories
   logic                t_wr_en;
   logic [KEY_AW-1:0]   wr_addr;
   logic [KEY_AW-1:0]   t_rd_addr, p_rd_addr;
   logic [31:0]         t_rd;
   logic [95:0]         p_rd;

   // Working values
   logic [CNT_W-1:0]    half, mid;
   logic signed [32:0]  num_w, den_w;
   logic [32:0]         rem_sh;
   logic [31:0]         pb_k, pe_k;
   logic signed [PROD_W-1:0] rounded, shifted;
   logic [31:0]         res_k;

   kpi_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_time_ram (
      .clock   (clock),
      .wr_en   (t_wr_en),
      .wr_addr (wr_addr),
      .wr_data (head.item.key_time),
      .rd_addr (t_rd_addr),
      .rd_data (t_rd)
   );

   kpi_ram #(.WIDTH(96), .DEPTH(MAX_KEYS)) u_pos_ram (
      .clock   (clock),
      .wr_en   (t_wr_en),
      .wr_addr (wr_addr),
      .wr_data ({head.item.z, head.item.y, head.item.x}),
      .rd_addr (p_rd_addr),
      .rd_data (p_rd)
   );

   assign wr_addr = count_ff[KEY_AW-1:0];
   assign half    = len_ff >> 1;
   assign mid     = lo_ff + half;
   assign num_w   = {item_ff.key_time[31], item_ff.key_time} - $signed({tb_ff[31], tb_ff});
   assign den_w   = $signed({t_rd[31], t_rd}) - $signed({tb_ff[31], tb_ff});
   assign rem_sh  = {rem_ff, 1'b0};

   // Pick the coordinate being blended
   always_comb begin
      case (idx_ff)
         2'd0:    begin pb_k = pb_ff[31:0];  pe_k = pe_ff[31:0];  end
         2'd1:    begin pb_k = pb_ff[63:32]; pe_k = pe_ff[63:32]; end
         default: begin pb_k = pb_ff[95:64]; pe_k = pe_ff[95:64]; end
      endcase
   end

   // Round half up, floor shift and add to the base coordinate
   assign rounded = prod_ff + $signed({{(PROD_W - DT_FRAC){1'b0}}, 1'b1, {(DT_FRAC - 1){1'b0}}});
   assign shifted = rounded >>> DT_FRAC;
   assign res_k   = pb_k + shifted[31:0];

   // Next state and datapath control
   always_comb begin
      state_in  = state_ff;
      item_in   = item_ff;
      count_in  = count_ff;
      lo_in     = lo_ff;
      len_in    = len_ff;
      b_in      = b_ff;
      e_in      = e_ff;
      tb_in     = tb_ff;
      den_in    = den_ff;
      rem_in    = rem_ff;
      q_in      = q_ff;
      dcnt_in   = dcnt_ff;
      dt_in     = dt_ff;
      pb_in     = pb_ff;
      pe_in     = pe_ff;
      delta_in  = delta_ff;
      prod_in   = prod_ff;
      idx_in    = idx_ff;
      rx_in     = rx_ff;
      ry_in     = ry_ff;
      rz_in     = rz_ff;
      st_in     = st_ff;
      pop       = 1'b0;
      t_wr_en   = 1'b0;
      t_rd_addr = '0;
      p_rd_addr = '0;
      rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               pop     = 1'b1;
               item_in = head.item;
               rx_in   = '0;
               ry_in   = '0;
               rz_in   = '0;
               st_in   = ST_OK;
               state_in = S_RESP;
               case (head.item.cmd)
                  CMD_APPEND: begin
                     if (count_ff < CNT_W'(MAX_KEYS)) begin
                        t_wr_en  = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end else begin
                        st_in = ST_FULL;
                     end
                  end
                  CMD_CLEAR: count_in = '0;
                  CMD_QUERY: begin
                     if (count_ff == '0) begin
                        st_in = ST_EMPTY;
                     end else begin
                        t_rd_addr = '0;
                        state_in  = S_TL;
                     end
                  end
                  default: st_in = ST_OK;
               endcase
            end
         end
         // Clamp below the first key
         S_TL: begin
            if (count_ff == CNT_W'(1) || item_ff.key_time <= $signed(t_rd)) begin
               p_rd_addr = '0;
               state_in  = S_SELD;
            end else begin
               t_rd_addr = KEY_AW'(count_ff - CNT_W'(1));
               state_in  = S_TN;
            end
         end
         // Clamp above the last key
         S_TN: begin
            if (item_ff.key_time >= $signed(t_rd)) begin
               p_rd_addr = KEY_AW'(count_ff - CNT_W'(1));
               state_in  = S_SELD;
            end else begin
               lo_in    = '0;
               len_in   = count_ff;
               state_in = S_SRCH;
            end
         end
         // Lower-bound search: issue probe or finish
         S_SRCH: begin
            if (len_ff == '0) begin
               e_in      = lo_ff[KEY_AW-1:0];
               b_in      = (lo_ff == '0) ? '0 : KEY_AW'(lo_ff - CNT_W'(1));
               t_rd_addr = (lo_ff == '0) ? '0 : KEY_AW'(lo_ff - CNT_W'(1));
               state_in  = S_BDAT;
            end else begin
               t_rd_addr = mid[KEY_AW-1:0];
               state_in  = S_SCHK;
            end
         end
         S_SCHK: begin
            if ($signed(t_rd) < item_ff.key_time) begin
               lo_in  = mid + CNT_W'(1);
               len_in = len_ff - half - CNT_W'(1);
            end else begin
               len_in = half;
            end
            state_in = S_SRCH;
         end
         S_BDAT: begin
            tb_in     = t_rd;
            t_rd_addr = e_ff;
            state_in  = S_EDAT;
         end
         // Span and weight set-up
         S_EDAT: begin
            if (den_w[32] || den_w == '0) begin
               p_rd_addr = b_ff;
               state_in  = S_SELD;
            end else if (num_w[32] || num_w == '0) begin
               dt_in    = '0;
               state_in = S_PRB;
            end else if (num_w[31:0] >= den_w[31:0]) begin
               dt_in    = {1'b1, {DT_FRAC{1'b0}}};
               state_in = S_PRB;
            end else begin
               rem_in   = num_w[31:0];
               den_in   = den_w[31:0];
               q_in     = '0;
               dcnt_in  = DCNT_W'(DT_FRAC - 1);
               state_in = S_DIV;
            end
         end
         // Restoring division, one quotient bit a cycle
         S_DIV: begin
            if (rem_sh >= {1'b0, den_ff}) begin
               rem_in = 32'(rem_sh - {1'b0, den_ff});
               q_in   = {q_ff[DT_FRAC-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[31:0];
               q_in   = {q_ff[DT_FRAC-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff - DCNT_W'(1);
            if (dcnt_ff == '0) begin
               dt_in    = {1'b0, q_in};
               state_in = S_PRB;
            end
         end
         S_PRB: begin
            p_rd_addr = b_ff;
            state_in  = S_PRE;
         end
         S_PRE: begin
            pb_in     = p_rd;
            p_rd_addr = e_ff;
            state_in  = S_PED;
         end
         S_PED: begin
            pe_in    = p_rd;
            idx_in   = '0;
            state_in = S_DELTA;
         end
         // Blend one coordinate through the delta, multiply and add states
         S_DELTA: begin
            delta_in = $signed({pe_k[31], pe_k}) - $signed({pb_k[31], pb_k});
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in  = PROD_W'(delta_ff * $signed({1'b0, dt_ff}));
            state_in = S_ADD;
         end
         S_ADD: begin
            case (idx_ff)
               2'd0:    rx_in = res_k;
               2'd1:    ry_in = res_k;
               default: rz_in = res_k;
            endcase
            idx_in   = idx_ff + 2'd1;
            state_in = (idx_ff == 2'd2) ? S_RESP : S_DELTA;
         end
         S_SELD: begin
            rx_in    = p_rd[31:0];
            ry_in    = p_rd[63:32];
            rz_in    = p_rd[95:64];
            state_in = S_RESP;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            state_in  = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Hold working payload
   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      lo_ff    <= lo_in;
      len_ff   <= len_in;
      b_ff     <= b_in;
      e_ff     <= e_in;
      tb_ff    <= tb_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      q_ff     <= q_in;
      dcnt_ff  <= dcnt_in;
      dt_ff    <= dt_in;
      pb_ff    <= pb_in;
      pe_ff    <= pe_in;
      delta_ff <= delta_in;
      prod_ff  <= prod_in;
      idx_ff   <= idx_in;
      rx_ff    <= rx_in;
      ry_ff    <= ry_in;
      rz_ff    <= rz_in;
      st_ff    <= st_in;
   end

   assign rsp_out_x  = rx_ff;
   assign rsp_out_y  = ry_ff;
   assign rsp_out_z  = rz_ff;
   assign rsp_status = st_ff;

endmodule
